// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
// Every check samples on the rising edge of clk and is skipped while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge.
`define SAP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition is never true.
`define SAP_ASSERT_NEVER(label, expr, msg) \
  `SAP_ASSERT(label, !(expr), msg)

`endif

// ===== hw/rtl/sap_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sap_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_ITEST   = 3'd1,
    MODE_MONITOR = 3'd2,
    MODE_ALARM   = 3'd3,
    MODE_RESET   = 3'd4,
    MODE_ATEST   = 3'd5
  } sap_mode_t;

  typedef enum logic [1:0] {
    PHASE_QUIET    = 2'd0,
    PHASE_COUNTING = 2'd1,
    PHASE_RAISED   = 2'd2
  } sap_phase_t;

  typedef enum logic [1:0] {
    CFG_TICK_PERIOD    = 2'd0,
    CFG_BLINK_ON_TICKS = 2'd1,
    CFG_PERSIST_LIMIT  = 2'd2
  } sap_cfg_index_t;

  typedef struct packed {
    logic [7:0]  tick_period;
    logic [7:0]  blink_on_ticks;
    logic [15:0] persist_limit;
  } sap_cfg_t;

  typedef struct packed {
    logic [7:0] drive;
    sap_mode_t  mode;
    sap_phase_t phase;
  } sap_result_t;

  localparam logic [7:0]  TICK_PERIOD_RST    = 8'd150;
  localparam logic [7:0]  BLINK_ON_TICKS_RST = 8'd75;
  localparam logic [15:0] PERSIST_LIMIT_RST  = 16'd150;

  localparam logic [7:0] DRIVE_ALL_OFF   = 8'hFF;
  localparam logic [7:0] DRIVE_ITEST     = 8'h83;
  localparam logic [7:0] DRIVE_ATEST     = 8'h10;
  localparam logic [7:0] DRIVE_ALARM     = 8'h30;
  localparam logic [15:0] PERSIST_MAX    = 16'hFFFF;

  localparam int unsigned SENSOR_BIT  = 3;
  localparam int unsigned RESET_BIT   = 4;
  localparam int unsigned ITEST_BIT   = 5;
  localparam int unsigned ATEST_BIT   = 6;
  localparam int unsigned MONITOR_BIT = 7;

  localparam logic [7:0] LEVEL_LAMPS [8] = '{
    8'h7F, 8'h6F, 8'h53, 8'h7F, 8'h33, 8'h7F, 8'h7F, 8'h7F
  };

endpackage

`default_nettype wire

// ===== hw/rtl/sap_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sap_cfg_regs (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [15:0]      cfg_data,
  output sap_pkg::sap_cfg_t     cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tick_period    <= sap_pkg::TICK_PERIOD_RST;
      cfg.blink_on_ticks <= sap_pkg::BLINK_ON_TICKS_RST;
      cfg.persist_limit  <= sap_pkg::PERSIST_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (sap_pkg::sap_cfg_index_t'(cfg_index))
        sap_pkg::CFG_TICK_PERIOD:    cfg.tick_period    <= cfg_data[7:0];
        sap_pkg::CFG_BLINK_ON_TICKS: cfg.blink_on_ticks <= cfg_data[7:0];
        sap_pkg::CFG_PERSIST_LIMIT:  cfg.persist_limit  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sap_panel_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sap_panel_core (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 accept,
  input  wire logic                 kind,
  input  wire logic [7:0]           pins,
  input  wire sap_pkg::sap_cfg_t    cfg,
  output sap_pkg::sap_result_t      result
);

`include "assert_macros.svh"

  sap_pkg::sap_mode_t  panel_mode, panel_mode_next;
  sap_pkg::sap_phase_t shake_phase, shake_phase_next;
  logic [7:0]          blink_count, blink_count_next;
  logic [15:0]         persist_count, persist_count_next;
  logic [7:0]          drive_latch, drive_latch_next;
  logic [8:0]          blink_inc;
  logic                sensor_high;
  logic                blink_lit;

  assign sensor_high = pins[sap_pkg::SENSOR_BIT];
  assign blink_inc   = {1'b0, blink_count} + 9'd1;
  assign blink_lit   = blink_count < cfg.blink_on_ticks;

  // The sample path follows the panel program in order, so later tests override earlier ones.
  always_comb begin
    panel_mode_next    = panel_mode;
    shake_phase_next   = shake_phase;
    blink_count_next   = blink_count;
    persist_count_next = persist_count;
    drive_latch_next   = drive_latch;

    if (kind) begin
      blink_count_next = (blink_inc >= {1'b0, cfg.tick_period}) ? 8'd0 : blink_inc[7:0];
    end else begin
      unique case (panel_mode)
        sap_pkg::MODE_IDLE: begin
          if (!pins[sap_pkg::ITEST_BIT])   panel_mode_next = sap_pkg::MODE_ITEST;
          if (!pins[sap_pkg::ATEST_BIT])   panel_mode_next = sap_pkg::MODE_ATEST;
          if (!pins[sap_pkg::MONITOR_BIT]) panel_mode_next = sap_pkg::MODE_MONITOR;
          drive_latch_next = sap_pkg::DRIVE_ALL_OFF;
        end
        sap_pkg::MODE_ITEST: begin
          if (pins[sap_pkg::ITEST_BIT])    drive_latch_next = sap_pkg::DRIVE_ITEST;
          if (!pins[sap_pkg::MONITOR_BIT]) panel_mode_next = sap_pkg::MODE_MONITOR;
          if (!pins[sap_pkg::ATEST_BIT])   panel_mode_next = sap_pkg::MODE_ATEST;
          if (!pins[sap_pkg::RESET_BIT])   panel_mode_next = sap_pkg::MODE_RESET;
        end
        sap_pkg::MODE_MONITOR, sap_pkg::MODE_ALARM: begin
          if (panel_mode == sap_pkg::MODE_MONITOR) begin
            drive_latch_next = sap_pkg::LEVEL_LAMPS[pins[3:1]];
          end
          unique case (shake_phase)
            sap_pkg::PHASE_QUIET: begin
              if (sensor_high) shake_phase_next = sap_pkg::PHASE_COUNTING;
            end
            sap_pkg::PHASE_COUNTING: begin
              if (!sensor_high) begin
                shake_phase_next   = sap_pkg::PHASE_QUIET;
                persist_count_next = 16'd0;
              end
              if (blink_count == 8'd0 && persist_count_next != sap_pkg::PERSIST_MAX) begin
                persist_count_next = persist_count_next + 16'd1;
              end
              if (persist_count_next >= cfg.persist_limit) begin
                shake_phase_next = sap_pkg::PHASE_RAISED;
              end
            end
            sap_pkg::PHASE_RAISED: begin
              drive_latch_next = sap_pkg::DRIVE_ALARM | {7'd0, blink_lit};
              panel_mode_next  = sap_pkg::MODE_ALARM;
              if (!sensor_high) begin
                shake_phase_next   = sap_pkg::PHASE_QUIET;
                panel_mode_next    = sap_pkg::MODE_MONITOR;
                persist_count_next = 16'd0;
              end
            end
            default: ;
          endcase
          if (!pins[sap_pkg::RESET_BIT]) panel_mode_next = sap_pkg::MODE_RESET;
          if (panel_mode == sap_pkg::MODE_ALARM && !sensor_high) begin
            panel_mode_next    = sap_pkg::MODE_MONITOR;
            drive_latch_next   = sap_pkg::DRIVE_ALL_OFF;
            persist_count_next = 16'd0;
            shake_phase_next   = sap_pkg::PHASE_QUIET;
          end
        end
        sap_pkg::MODE_RESET: begin
          if (pins[sap_pkg::RESET_BIT]) panel_mode_next = sap_pkg::MODE_IDLE;
        end
        sap_pkg::MODE_ATEST: begin
          if (pins[sap_pkg::ATEST_BIT])    drive_latch_next = sap_pkg::DRIVE_ATEST;
          if (!pins[sap_pkg::ITEST_BIT])   panel_mode_next = sap_pkg::MODE_ITEST;
          if (!pins[sap_pkg::MONITOR_BIT]) panel_mode_next = sap_pkg::MODE_MONITOR;
          if (!pins[sap_pkg::RESET_BIT])   panel_mode_next = sap_pkg::MODE_RESET;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      panel_mode    <= sap_pkg::MODE_IDLE;
      shake_phase   <= sap_pkg::PHASE_QUIET;
      blink_count   <= 8'd0;
      persist_count <= 16'd0;
      drive_latch   <= sap_pkg::DRIVE_ALL_OFF;
    end else if (accept) begin
      panel_mode    <= panel_mode_next;
      shake_phase   <= shake_phase_next;
      blink_count   <= blink_count_next;
      persist_count <= persist_count_next;
      drive_latch   <= drive_latch_next;
    end
  end

  assign result.drive = drive_latch_next;
  assign result.mode  = panel_mode_next;
  assign result.phase = shake_phase_next;

  `SAP_ASSERT(a_alarm_has_raised_phase,
    panel_mode == sap_pkg::MODE_ALARM |-> shake_phase == sap_pkg::PHASE_RAISED,
    "Alarm mode without a raised vibration phase.")
  `SAP_ASSERT(a_state_holds_when_idle,
    !accept |=> $stable(panel_mode) && $stable(shake_phase) && $stable(drive_latch),
    "Panel state changed without a request.")
  `SAP_ASSERT(a_tick_keeps_mode,
    accept && kind |=> $stable(panel_mode) && $stable(persist_count),
    "A tick request changed the panel mode or persistence count.")

endmodule

`default_nettype wire

// ===== hw/rtl/sap_out_skid.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sap_out_skid (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  accept,
  input  wire sap_pkg::sap_result_t  result,
  output logic                       full,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output sap_pkg::sap_result_t       out_result
);

`include "assert_macros.svh"

  logic                 skid_valid;
  sap_pkg::sap_result_t skid_result;
  logic                 take;

  assign take = out_valid && !out_stall;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        skid_valid <= 1'b0;
      end
    end else if (accept) begin
      if (out_valid && !take) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (take) begin
        out_result <= skid_result;
      end
    end else if (accept) begin
      if (out_valid && !take) begin
        skid_result <= result;
      end else begin
        out_result <= result;
      end
    end
  end

  `SAP_ASSERT_NEVER(a_skid_without_out, skid_valid && !out_valid,
    "Skid stage holds a request while the output register is empty.")
  `SAP_ASSERT(a_blocked_accept_fills_skid,
    accept && out_valid && out_stall && !skid_valid |=> skid_valid,
    "A request taken behind a stalled output was not kept.")
  `SAP_ASSERT(a_skid_moves_forward,
    skid_valid && !out_stall |=> out_valid && !skid_valid,
    "Skid stage did not drain when the output was taken.")

endmodule

`default_nettype wire

// ===== hw/rtl/seismic_alarm_panel_fsm.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake                  Payload
// --------  -------------------------  ----------------------------------
// input     in_valid / in_stall        kind[0:0], pins[7:0]
// output    out_valid / out_stall      drive[7:0], mode[2:0], vibration_phase[1:0]
// config    cfg_valid / cfg_ready      cfg_index[1:0], cfg_data[15:0]
//
// Each accepted result is registered at the output, or in the skid while it stalls.
// A new request can be taken every cycle unless stalled; the update is a single pass.
// A two-entry output buffer lets one more request in while a result is stalled.
// Reset is synchronous and returns the panel to idle with all lamps off.
// Configuration writes are always ready; index three is ignored.

module seismic_alarm_panel_fsm (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        kind,
  input  wire logic [7:0]  pins,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       drive,
  output logic [2:0]       mode,
  output logic [1:0]       vibration_phase,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  sap_pkg::sap_cfg_t    cfg;
  sap_pkg::sap_result_t result;
  sap_pkg::sap_result_t out_result;
  logic                 accept;
  logic                 full;

  assign in_stall = full;
  assign accept   = in_valid && !in_stall;

  sap_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sap_panel_core u_core (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .kind   (kind),
    .pins   (pins),
    .cfg    (cfg),
    .result (result)
  );

  sap_out_skid u_out (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .result     (result),
    .full       (full),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_result (out_result)
  );

  assign drive           = out_result.drive;
  assign mode            = out_result.mode;
  assign vibration_phase = out_result.phase;

endmodule

`default_nettype wire
